// ----- sv/bsws_pkg.sv -----
`timescale 1ns / 1ps

package bsws_pkg;

   localparam int DEPTH   = 256;
   localparam int ADDR_W  = $clog2(DEPTH);
   localparam int FILL_W  = 9;
   localparam int COUNT_W = 9;
   localparam int WORD_W  = 32;

   localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

   localparam logic [2:0] OP_PUSH   = 3'd0;
   localparam logic [2:0] OP_POP    = 3'd1;
   localparam logic [2:0] OP_PEEK   = 3'd2;
   localparam logic [2:0] OP_SEARCH = 3'd3;
   localparam logic [2:0] OP_CLEAR  = 3'd4;

   localparam logic [1:0] STATUS_OK    = 2'd0;
   localparam logic [1:0] STATUS_FULL  = 2'd1;
   localparam logic [1:0] STATUS_EMPTY = 2'd2;

   typedef enum logic [2:0] {
      KIND_PUSH   = 3'd0,
      KIND_POP    = 3'd1,
      KIND_PEEK   = 3'd2,
      KIND_SEARCH = 3'd3,
      KIND_CLEAR  = 3'd4,
      KIND_NOP    = 3'd5
   } bsws_kind_type;

   typedef struct packed {
      logic [2:0]               op;
      logic signed [WORD_W-1:0] value;
   } bsws_req_type;

   typedef struct packed {
      logic [1:0]               status;
      logic signed [WORD_W-1:0] data;
      logic [COUNT_W-1:0]       match_count;
   } bsws_rsp_type;

   typedef struct packed {
      bsws_kind_type     kind;
      logic [WORD_W-1:0] value;
   } bsws_cmd_type;

endpackage

// ----- sv/bounded_stack_with_search_core.sv -----
`timescale 1ns / 1ps

// Bounded LIFO of signed 32-bit words, up to 256 entries, usable capacity set by csr_wdata
// (a write also empties the stack; zero means no stack, so push answers full and pop, peek
// and search empty). Requests enter a two-entry queue and are carried out one at a time by
// the back end, which owns a single-port-read word memory: push, clear, unused codes and
// refused requests are answered when taken, pop and peek from ST_READ after a registered
// memory read, and search from ST_SDONE after walking one entry per cycle through the read
// port in ST_SEARCH while later requests wait. Results wait in a two-entry queue; the
// back end starts a request only when that queue has room. No clearing pass is needed after reset.
module bounded_stack_with_search_core (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_push,
   output logic                             req_full,
   input  bsws_pkg::bsws_req_type           req_item,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output bsws_pkg::bsws_rsp_type           rsp_item,
   input  logic                             csr_we,
   input  logic [bsws_pkg::FILL_W-1:0]      csr_wdata
);
   import bsws_pkg::*;

   logic         cmd_valid;
   logic         cmd_ready;
   bsws_cmd_type cmd;

   bsws_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_push  (req_push),
      .req_full  (req_full),
      .req_item  (req_item),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd)
   );

   bsws_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd_ready (cmd_ready),
      .cmd       (cmd),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .rsp_empty (rsp_empty),
      .rsp_pop   (rsp_pop),
      .rsp_item  (rsp_item)
   );

endmodule

// ----- sv/bsws_front.sv -----
`timescale 1ns / 1ps

module bsws_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_push,
   output logic                  req_full,
   input  bsws_pkg::bsws_req_type req_item,
   output logic                  cmd_valid,
   input  logic                  cmd_ready,
   output bsws_pkg::bsws_cmd_type cmd
);
   import bsws_pkg::*;

   bsws_cmd_type q_ff [2];
   logic         wptr_ff, wptr_in;
   logic         rptr_ff, rptr_in;
   logic [1:0]   cnt_ff, cnt_in;
   logic         wr_en, rd_en;
   bsws_cmd_type classed;

   always_comb begin
      classed.value = req_item.value;
      unique case (req_item.op)
         OP_PUSH:   classed.kind = KIND_PUSH;
         OP_POP:    classed.kind = KIND_POP;
         OP_PEEK:   classed.kind = KIND_PEEK;
         OP_SEARCH: classed.kind = KIND_SEARCH;
         OP_CLEAR:  classed.kind = KIND_CLEAR;
         default:   classed.kind = KIND_NOP;
      endcase
   end

   assign req_full  = (cnt_ff == 2'd2);
   assign cmd_valid = (cnt_ff != 2'd0);
   assign cmd       = q_ff[rptr_ff];
   assign wr_en     = req_push && !req_full;
   assign rd_en     = cmd_valid && cmd_ready;

   always_comb begin
      wptr_in = wr_en ? !wptr_ff : wptr_ff;
      rptr_in = rd_en ? !rptr_ff : rptr_ff;
      cnt_in  = cnt_ff + 2'(wr_en) - 2'(rd_en);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff <= 1'b0;
         rptr_ff <= 1'b0;
         cnt_ff  <= 2'd0;
      end else begin
         wptr_ff <= wptr_in;
         rptr_ff <= rptr_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         q_ff[wptr_ff] <= classed;
      end
   end

endmodule

// ----- sv/bsws_back.sv -----
`timescale 1ns / 1ps

module bsws_back (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             cmd_valid,
   output logic                             cmd_ready,
   input  bsws_pkg::bsws_cmd_type           cmd,
   input  logic                             csr_we,
   input  logic [bsws_pkg::FILL_W-1:0]      csr_wdata,
   output logic                             rsp_empty,
   input  logic                             rsp_pop,
   output bsws_pkg::bsws_rsp_type           rsp_item
);
   import bsws_pkg::*;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_READ   = 4'b0010,
      ST_SEARCH = 4'b0100,
      ST_SDONE  = 4'b1000
   } bsws_state_type;

   bsws_state_type     state_ff, state_in;
   logic [FILL_W-1:0]  fill_ff, fill_in;
   logic [FILL_W-1:0]  cap_ff, cap_in;
   logic [ADDR_W-1:0]  idx_ff, idx_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [WORD_W-1:0]  value_ff, value_in;
   logic               rd_pend_ff, rd_pend_in;
   logic [WORD_W-1:0]  rd_data_ff;
   logic [WORD_W-1:0]  mem_ff [DEPTH];

   logic               mem_we, mem_re;
   logic [ADDR_W-1:0]  wr_addr, rd_addr;
   logic [WORD_W-1:0]  wr_data;
   logic [FILL_W-1:0]  cap_use, fill_m1;
   logic               is_full, is_empty, take, space, match_inc;
   logic [COUNT_W-1:0] count_next;
   logic               res_valid;
   bsws_rsp_type       res;

   bsws_rsp_type       oq_ff [2];
   logic               oq_wptr_ff, oq_rptr_ff;
   logic [1:0]         oq_cnt_ff;
   logic               oq_rd;

   assign cap_use    = (cap_ff > FILL_W'(DEPTH)) ? FILL_W'(DEPTH) : cap_ff;
   assign fill_m1    = fill_ff - FILL_W'(1);
   assign is_full    = (cap_use == '0) || (fill_ff >= cap_use);
   assign is_empty   = (cap_use == '0) || (fill_ff == '0);
   assign space      = (oq_cnt_ff != 2'd2);
   assign cmd_ready  = (state_ff == ST_IDLE) && space;
   assign take       = cmd_valid && cmd_ready;
   assign match_inc  = rd_pend_ff && (rd_data_ff == value_ff) && (count_ff != COUNT_MAX);
   assign count_next = count_ff + COUNT_W'(match_inc);

   always_comb begin
      state_in   = state_ff;
      fill_in    = fill_ff;
      cap_in     = cap_ff;
      idx_in     = idx_ff;
      count_in   = count_ff;
      value_in   = value_ff;
      rd_pend_in = 1'b0;
      mem_we     = 1'b0;
      mem_re     = 1'b0;
      wr_addr    = fill_ff[ADDR_W-1:0];
      wr_data    = cmd.value;
      rd_addr    = '0;
      res_valid  = 1'b0;
      res        = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               value_in  = cmd.value;
               res_valid = 1'b1;
               res.status = STATUS_OK;
               unique case (cmd.kind)
                  KIND_PUSH: begin
                     if (is_full) begin
                        res.status = STATUS_FULL;
                     end else begin
                        mem_we  = 1'b1;
                        fill_in = fill_ff + FILL_W'(1);
                     end
                  end
                  KIND_POP, KIND_PEEK: begin
                     if (is_empty) begin
                        res.status = STATUS_EMPTY;
                     end else begin
                        res_valid = 1'b0;
                        mem_re    = 1'b1;
                        rd_addr   = fill_m1[ADDR_W-1:0];
                        state_in  = ST_READ;
                        if (cmd.kind == KIND_POP) begin
                           fill_in = fill_m1;
                        end
                     end
                  end
                  KIND_SEARCH: begin
                     if (is_empty) begin
                        res.status = STATUS_EMPTY;
                     end else begin
                        res_valid = 1'b0;
                        idx_in    = '0;
                        count_in  = '0;
                        state_in  = ST_SEARCH;
                     end
                  end
                  KIND_CLEAR: begin
                     fill_in = '0;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            res_valid  = 1'b1;
            res.status = STATUS_OK;
            res.data   = rd_data_ff;
            state_in   = ST_IDLE;
         end
         ST_SEARCH: begin
            mem_re     = 1'b1;
            rd_addr    = idx_ff;
            rd_pend_in = 1'b1;
            count_in   = count_next;
            if (idx_ff == fill_m1[ADDR_W-1:0]) begin
               state_in = ST_SDONE;
            end else begin
               idx_in = idx_ff + ADDR_W'(1);
            end
         end
         ST_SDONE: begin
            res_valid       = 1'b1;
            res.status      = STATUS_OK;
            res.match_count = count_next;
            state_in        = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (csr_we) begin
         cap_in  = csr_wdata;
         fill_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         fill_ff    <= '0;
         cap_ff     <= FILL_W'(DEPTH);
         rd_pend_ff <= 1'b0;
      end else begin
         state_ff   <= state_in;
         fill_ff    <= fill_in;
         cap_ff     <= cap_in;
         rd_pend_ff <= rd_pend_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff   <= idx_in;
      count_ff <= count_in;
      value_ff <= value_in;
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (mem_re) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rsp_empty = (oq_cnt_ff == 2'd0);
   assign rsp_item  = oq_ff[oq_rptr_ff];
   assign oq_rd     = rsp_pop && !rsp_empty;

   always_ff @(posedge clock) begin
      if (reset) begin
         oq_wptr_ff <= 1'b0;
         oq_rptr_ff <= 1'b0;
         oq_cnt_ff  <= 2'd0;
      end else begin
         oq_wptr_ff <= res_valid ? !oq_wptr_ff : oq_wptr_ff;
         oq_rptr_ff <= oq_rd ? !oq_rptr_ff : oq_rptr_ff;
         oq_cnt_ff  <= oq_cnt_ff + 2'(res_valid) - 2'(oq_rd);
      end
   end

   always_ff @(posedge clock) begin
      if (res_valid) begin
         oq_ff[oq_wptr_ff] <= res;
      end
   end

`ifndef SYNTHESIS
   a_fill_in_cap: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= cap_use)
      else $error("fill level above usable capacity");

   a_oq_room: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> (oq_cnt_ff != 2'd2) || oq_rd)
      else $error("result queue overflow");

   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (take && cmd.kind == KIND_PUSH && !is_full && !csr_we)
      |=> fill_ff == $past(fill_ff) + FILL_W'(1))
      else $error("accepted push did not advance fill level");

   a_pend_from_search: assert property (@(posedge clock) disable iff (reset)
      rd_pend_ff |-> $past(state_ff == ST_SEARCH))
      else $error("compare without search read");
`endif

endmodule
